[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the PID controller modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_PROP(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

[src/pid4_pkg.sv]
// ----------------------------------------------------------------------------
// pid4_pkg
// Widths, register codes, microcode format and program for the PID unit.
// ----------------------------------------------------------------------------
package pid4_pkg;

    localparam int CHANNELS_DEF = 4;

    localparam int GAIN_W     = 16;
    localparam int DT_W       = 16;
    localparam int SPEED_W    = 16;
    localparam int CH_IDX_W   = 2;
    localparam int ERR_W      = 17;
    localparam int DE_W       = 18;
    localparam int MAG_W      = 17;
    localparam int INTEG_W    = 48;
    localparam int PROD_W     = 42;
    localparam int ACC_W      = 52;
    localparam int DIVIDEND_W = 49;
    localparam int DIVISOR_W  = 16;
    localparam int DRIVE_W    = 32;
    localparam int UPC_W      = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd256;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd51;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd0;

    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DT_E,
        MUL_KP_E,
        MUL_KI_LO,
        MUL_KI_HI,
        MUL_KD_MAG
    } t_mul_sel;

    typedef enum logic [3:0] {
        ACC_NONE,
        ACC_INTEG,
        ACC_LOAD_P,
        ACC_ADD_ILO,
        ACC_ADD_IHI,
        ACC_DIV_LOAD,
        ACC_ADD_D,
        ACC_FINISH,
        ACC_CLEAR
    } t_acc_op;

    typedef enum logic [1:0] {
        J_NONE,
        J_SKIP,
        J_DT_ZERO,
        J_DIV_MORE
    } t_jcond;

    typedef struct packed {
        t_mul_sel mul;
        t_acc_op  acc;
        logic     ld_de;
        logic     div_step;
        t_jcond   jc;
        t_upc     target;
        logic     done;
    } t_uword;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

    localparam t_upc PC_DISPATCH = 4'd0;
    localparam t_upc PC_ERROR    = 4'd1;
    localparam t_upc PC_INTEG    = 4'd2;
    localparam t_upc PC_PTERM    = 4'd3;
    localparam t_upc PC_ILO      = 4'd4;
    localparam t_upc PC_IHI      = 4'd5;
    localparam t_upc PC_DIV_LOAD = 4'd6;
    localparam t_upc PC_DIV_LOOP = 4'd7;
    localparam t_upc PC_DTERM    = 4'd8;
    localparam t_upc PC_FINISH   = 4'd9;
    localparam t_upc PC_CLEAR    = 4'd10;

    localparam t_uword UWORD_NOP = '{
        mul: MUL_NONE, acc: ACC_NONE, ld_de: 1'b0, div_step: 1'b0,
        jc: J_NONE, target: '0, done: 1'b0
    };

    // Control store: one word per step.
    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        w = UWORD_NOP;
        unique case (pc)
            PC_DISPATCH: begin
                w.jc     = J_SKIP;
                w.target = PC_CLEAR;
            end
            PC_ERROR: begin
                w.mul   = MUL_DT_E;
                w.ld_de = 1'b1;
            end
            PC_INTEG: begin
                w.acc = ACC_INTEG;
                w.mul = MUL_KP_E;
            end
            PC_PTERM: begin
                w.acc = ACC_LOAD_P;
                w.mul = MUL_KI_LO;
            end
            PC_ILO: begin
                w.acc = ACC_ADD_ILO;
                w.mul = MUL_KI_HI;
            end
            PC_IHI: begin
                w.acc = ACC_ADD_IHI;
                w.mul = MUL_KD_MAG;
            end
            PC_DIV_LOAD: begin
                w.acc    = ACC_DIV_LOAD;
                w.jc     = J_DT_ZERO;
                w.target = PC_FINISH;
            end
            PC_DIV_LOOP: begin
                w.div_step = 1'b1;
                w.jc       = J_DIV_MORE;
                w.target   = PC_DIV_LOOP;
            end
            PC_DTERM: begin
                w.acc = ACC_ADD_D;
            end
            PC_FINISH: begin
                w.acc  = ACC_FINISH;
                w.done = 1'b1;
            end
            PC_CLEAR: begin
                w.acc  = ACC_CLEAR;
                w.done = 1'b1;
            end
            default: begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

[src/pid4_div.sv]
// ----------------------------------------------------------------------------
// pid4_div
// Unsigned restoring divider, one quotient bit per step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pid4_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pid4_pkg::t_div_ctl                 i_ctl,
    input  logic [pid4_pkg::DIVIDEND_W-1:0]    i_dividend,
    input  logic [pid4_pkg::DIVISOR_W-1:0]     i_divisor,
    output logic [pid4_pkg::DIVIDEND_W-1:0]    o_quotient,
    output logic                               o_more
);
    import pid4_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [CNT_W-1:0]      r_cnt;

    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= CNT_W'(DIVIDEND_W);
        end else if (i_ctl.step) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Dividend bits shift out of the top while quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (i_ctl.step) begin
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_more     = (r_cnt != CNT_W'(1));

    `ASSERT_PROP(a_step_counted, i_clk, i_rst_n, i_ctl.step |-> (r_cnt != '0), "divider stepped with no bits left")
    `ASSERT_PROP(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(DIVIDEND_W), "divider count out of range")
    `ASSERT_NEXT(a_load_count, i_clk, i_rst_n, i_ctl.load, r_cnt == CNT_W'(DIVIDEND_W), "divider load lost")

endmodule

[src/pid_controller_four_channel_unit.sv]
// Flow: a new item is accepted only after the result of the last one has been loaded
//   into the output register; a clear or an out-of-range channel jumps to the clear step.
// Update: the D term goes through a serial divider (one quotient bit per cycle,
//   49 bits), which is skipped when step_time is 0.
// Reset (synchronous, active low): gains to 1.0 / 0.2 / 0.0, all channel integrals
//   and last errors to zero, sequencer idle, no result pending.
// ----------------------------------------------------------------------------
// pid_controller_four_channel_unit
// Microcoded positional PID for several channels sharing one multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pid_controller_four_channel_unit #(
    parameter int CHANNELS = pid4_pkg::CHANNELS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_func,
    input  logic [pid4_pkg::CH_IDX_W-1:0]          i_channel,
    input  logic signed [pid4_pkg::SPEED_W-1:0]    i_setpoint,
    input  logic signed [pid4_pkg::SPEED_W-1:0]    i_measured,
    input  logic [pid4_pkg::DT_W-1:0]              i_step_time,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [pid4_pkg::DRIVE_W-1:0]    o_drive,
    output logic                                   o_saturated,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pid4_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pid4_pkg::GAIN_W-1:0]            i_cfg_data
);
    import pid4_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    // Gains
    logic [GAIN_W-1:0] r_prop_gain, r_integ_gain, r_deriv_gain;

    // Sequencer
    logic   r_busy, n_busy;
    t_upc   r_pc, n_pc;
    t_uword cw;
    logic   w_jump;

    // Latched transaction
    logic                      r_func;
    logic [CH_IDX_W-1:0]       r_channel;
    logic signed [SPEED_W-1:0] r_setpoint, r_measured;
    logic [DT_W-1:0]           r_step_time;

    // Channel state
    logic signed [INTEG_W-1:0] r_integ_mem [CHANNELS];
    logic signed [ERR_W-1:0]   r_lerr_mem  [CHANNELS];

    // Datapath
    logic signed [DE_W-1:0]    r_de;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic                      r_sat;

    logic [CH_W-1:0]           w_idx;
    logic                      w_ch_ok;
    logic signed [ERR_W-1:0]   w_err;
    logic [DE_W-1:0]           w_de_abs;
    logic [MAG_W-1:0]          w_mag;
    logic [GAIN_W-1:0]         w_mul_a;
    logic signed [24:0]        w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [INTEG_W:0]   w_integ_sum;
    logic signed [INTEG_W-1:0] w_integ_clamp;
    logic                      w_integ_ovf;
    logic [ACC_W-1:0]          w_q_ext;
    logic                      w_drive_ovf;
    logic signed [DRIVE_W-1:0] w_drive_clamp;

    // Divider
    t_div_ctl                  w_div_ctl;
    logic [DIVIDEND_W-1:0]     w_quotient;
    logic                      w_div_more;

    // Output register
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive;
    logic                      r_sat_out;
    logic                      w_out_free, w_out_load, w_in_accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= PROP_GAIN_RST;
            r_integ_gain <= INTEG_GAIN_RST;
            r_deriv_gain <= DERIV_GAIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                REG_INTEG_GAIN: r_integ_gain <= i_cfg_data;
                REG_DERIV_GAIN: r_deriv_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign w_in_accept = i_in_valid && !r_busy;
    assign o_in_stall  = r_busy;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign cw          = r_busy ? ucode(r_pc) : UWORD_NOP;
    assign w_out_load  = cw.done && w_out_free;

    always_comb begin
        unique case (cw.jc)
            J_SKIP:     w_jump = r_func || !w_ch_ok;
            J_DT_ZERO:  w_jump = (r_step_time == '0);
            J_DIV_MORE: w_jump = w_div_more;
            default:    w_jump = 1'b0;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (w_in_accept) begin
                n_busy = 1'b1;
                n_pc   = PC_DISPATCH;
            end
        end else if (cw.done) begin
            // hold the last step until the output register frees up
            if (w_out_free) begin
                n_busy = 1'b0;
            end
        end else if (w_jump) begin
            n_pc = cw.target;
        end else begin
            n_pc = r_pc + t_upc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_DISPATCH;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_func      <= i_func;
            r_channel   <= i_channel;
            r_setpoint  <= i_setpoint;
            r_measured  <= i_measured;
            r_step_time <= i_step_time;
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    assign w_idx    = CH_W'(r_channel);
    assign w_ch_ok  = (int'(r_channel) < CHANNELS);
    assign w_err    = {r_setpoint[SPEED_W-1], r_setpoint} - {r_measured[SPEED_W-1], r_measured};
    assign w_de_abs = r_de[DE_W-1] ? -r_de : r_de;
    assign w_mag    = w_de_abs[MAG_W-1:0];

    always_comb begin
        unique case (cw.mul)
            MUL_DT_E: begin
                w_mul_a = r_step_time;
                w_mul_b = {{8{w_err[ERR_W-1]}}, w_err};
            end
            MUL_KP_E: begin
                w_mul_a = r_prop_gain;
                w_mul_b = {{8{w_err[ERR_W-1]}}, w_err};
            end
            MUL_KI_LO: begin
                w_mul_a = r_integ_gain;
                w_mul_b = {1'b0, r_integ[23:0]};
            end
            MUL_KI_HI: begin
                w_mul_a = r_integ_gain;
                w_mul_b = {r_integ[INTEG_W-1], r_integ[INTEG_W-1:24]};
            end
            MUL_KD_MAG: begin
                w_mul_a = r_deriv_gain;
                w_mul_b = {8'b0, w_mag};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = $signed({1'b0, w_mul_a}) * w_mul_b;

    always_comb begin
        w_integ_sum = {r_integ_mem[w_idx][INTEG_W-1], r_integ_mem[w_idx]}
                    + {{(INTEG_W+1-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        w_integ_ovf = (w_integ_sum[INTEG_W] != w_integ_sum[INTEG_W-1]);
        if (w_integ_ovf) begin
            w_integ_clamp = w_integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end else begin
            w_integ_clamp = w_integ_sum[INTEG_W-1:0];
        end
    end

    // I term = (ki*hi) << 8 + (ki*lo) >> 16, which equals the floor of ki*integ / 2^16
    always_comb begin
        w_q_ext = {{(ACC_W-DIVIDEND_W){1'b0}}, w_quotient};
        n_acc   = r_acc;
        case (cw.acc)
            ACC_LOAD_P:  n_acc = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            ACC_ADD_ILO: n_acc = r_acc + {{(ACC_W-PROD_W+16){1'b0}}, r_prod[PROD_W-1:16]};
            ACC_ADD_IHI: n_acc = r_acc + {{(ACC_W-PROD_W-8){r_prod[PROD_W-1]}}, r_prod, 8'b0};
            ACC_ADD_D:   n_acc = r_acc + (r_de[DE_W-1] ? -w_q_ext : w_q_ext);
            default:     n_acc = r_acc;
        endcase
    end

    always_comb begin
        w_drive_ovf = !((r_acc[ACC_W-1:DRIVE_W-1] == '0) || (r_acc[ACC_W-1:DRIVE_W-1] == '1));
        if (w_drive_ovf) begin
            w_drive_clamp = r_acc[ACC_W-1] ? DRIVE_MIN : DRIVE_MAX;
        end else begin
            w_drive_clamp = r_acc[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cw.mul != MUL_NONE) begin
            r_prod <= w_prod;
        end
        r_acc <= n_acc;
        if (cw.ld_de) begin
            r_de  <= {w_err[ERR_W-1], w_err}
                   - {r_lerr_mem[w_idx][ERR_W-1], r_lerr_mem[w_idx]};
            r_sat <= 1'b0;
        end
        if (cw.acc == ACC_INTEG) begin
            r_integ <= w_integ_clamp;
            r_sat   <= w_integ_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_integ_mem[i] <= '0;
                r_lerr_mem[i]  <= '0;
            end
        end else begin
            if (cw.ld_de) begin
                r_lerr_mem[w_idx] <= w_err;
            end
            if (cw.acc == ACC_INTEG) begin
                r_integ_mem[w_idx] <= w_integ_clamp;
            end
            if ((cw.acc == ACC_CLEAR) && w_ch_ok) begin
                r_integ_mem[w_idx] <= '0;
                r_lerr_mem[w_idx]  <= '0;
            end
        end
    end

    assign w_div_ctl.load = (cw.acc == ACC_DIV_LOAD);
    assign w_div_ctl.step = cw.div_step;

    pid4_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend ({r_prod[DIVIDEND_W-17:0], 16'b0}),
        .i_divisor  (r_step_time),
        .o_quotient (w_quotient),
        .o_more     (w_div_more)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (cw.acc == ACC_FINISH) begin
                r_drive   <= w_drive_clamp;
                r_sat_out <= r_sat || w_drive_ovf;
            end else begin
                r_drive   <= '0;
                r_sat_out <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_saturated = r_sat_out;

    `ASSERT_NEXT(a_done_delivers, i_clk, i_rst_n, w_out_load, o_out_valid && !r_busy, "finished transaction not delivered")
    `ASSERT_NEXT(a_clear_zero, i_clk, i_rst_n, w_out_load && (cw.acc == ACC_CLEAR), (o_drive == '0) && !o_saturated, "clear result not zero")
    `ASSERT_PROP(a_pc_range, i_clk, i_rst_n, r_busy |-> (r_pc <= PC_CLEAR), "step counter left the program")

endmodule

[verif/tb_pid_controller_four_channel_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pid_controller_four_channel_unit
// Self-checking bench for the four-channel positional PID. It drives updates
// and clears with bursty timing and back-pressure on the result side. A
// fixed-point predictor tracks gains, integrals and last errors. Each
// accepted result is matched in order against the predicted drive and
// saturation flag.
// ----------------------------------------------------------------------------
module tb_pid_controller_four_channel_unit;
    import pid4_pkg::*;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;
    localparam int   NUM_CH      = CHANNELS_DEF;
    localparam int   HOLD_CYCLES = 800;
    localparam int   IDLE_LIMIT  = 5000;
    localparam int   DRAIN_WAIT  = 70;
    localparam longint INTEG_HI  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint INTEG_LO  = -INTEG_HI - 1;
    localparam longint DRIVE_HI  = 64'sh0000_0000_7FFF_FFFF;
    localparam longint DRIVE_LO  = -DRIVE_HI - 1;

    typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY} t_rx_mode;

    typedef struct {
        logic [CH_IDX_W-1:0]       ch;
        logic signed [DRIVE_W-1:0] drive;
        logic                      saturated;
    } t_drive_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_func = FUNC_UPDATE;
    logic [CH_IDX_W-1:0]        i_channel = '0;
    logic signed [SPEED_W-1:0]  i_setpoint = '0;
    logic signed [SPEED_W-1:0]  i_measured = '0;
    logic [DT_W-1:0]            i_step_time = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [DRIVE_W-1:0]  o_drive;
    logic                       o_saturated;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [GAIN_W-1:0]          i_cfg_data = '0;

    // predictor state
    longint kp_model, ki_model, kd_model;
    longint integ_model [NUM_CH];
    longint err_model [NUM_CH];
    t_drive_result drive_expected [$];
    t_drive_result exp_head;

    int       err_count = 0;
    int       items_sent = 0;
    int       clears_sent = 0;
    int       gain_writes = 0;
    int       sat_seen = 0;
    int       burst_left = 0;
    bit       gaps_on = 1'b0;
    t_rx_mode rx_mode = RX_OPEN;
    int       hold_requests = 0;
    int       hold_served = 0;
    int       hold_left = 0;
    int       idle_cycles = 0;

    pid_controller_four_channel_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_channel   (i_channel),
        .i_setpoint  (i_setpoint),
        .i_measured  (i_measured),
        .i_step_time (i_step_time),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_drive     (o_drive),
        .o_saturated (o_saturated),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void reset_model();
        kp_model = longint'(PROP_GAIN_RST);
        ki_model = longint'(INTEG_GAIN_RST);
        kd_model = longint'(DERIV_GAIN_RST);
        for (int c = 0; c < NUM_CH; c++) begin
            integ_model[c] = 0;
            err_model[c]   = 0;
        end
    endfunction

    function automatic t_drive_result predict_drive(input logic func,
                                                    input logic [CH_IDX_W-1:0] ch,
                                                    input logic signed [SPEED_W-1:0] sp,
                                                    input logic signed [SPEED_W-1:0] ms,
                                                    input logic [DT_W-1:0] dt);
        t_drive_result r;
        longint err, integ, p_term, i_term, de, mag, quo, d_term, total, dtv;
        logic   sat;
        r.ch        = ch;
        r.drive     = '0;
        r.saturated = 1'b0;
        if (func == FUNC_CLEAR) begin
            integ_model[ch] = 0;
            err_model[ch]   = 0;
            return r;
        end
        sat    = 1'b0;
        dtv    = longint'(dt);
        err    = longint'(sp) - longint'(ms);
        p_term = kp_model * err;
        integ  = integ_model[ch] + err * dtv;
        if (integ > INTEG_HI) begin
            integ = INTEG_HI;
            sat   = 1'b1;
        end else if (integ < INTEG_LO) begin
            integ = INTEG_LO;
            sat   = 1'b1;
        end
        integ_model[ch] = integ;
        i_term = (ki_model * integ) >>> 16;
        // D term: magnitude divided, sign restored, so it truncates toward zero
        de     = err - err_model[ch];
        d_term = 0;
        if (dtv != 0) begin
            mag    = (de < 0) ? -de : de;
            quo    = (kd_model * mag * 65536) / dtv;
            d_term = (de < 0) ? -quo : quo;
        end
        err_model[ch] = err;
        total = p_term + i_term + d_term;
        if (total > DRIVE_HI) begin
            total = DRIVE_HI;
            sat   = 1'b1;
        end else if (total < DRIVE_LO) begin
            total = DRIVE_LO;
            sat   = 1'b1;
        end
        r.drive     = total[DRIVE_W-1:0];
        r.saturated = sat;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (o_saturated)
                sat_seen++;
            if (drive_expected.size() == 0) begin
                $display("%0t: unexpected result: expected none, got drive %0d sat %0b",
                         $time, o_drive, o_saturated);
                err_count++;
            end else begin
                exp_head = drive_expected.pop_front();
                if (o_drive !== exp_head.drive) begin
                    $display("%0t: ch %0d drive mismatch: expected %0d, got %0d",
                             $time, exp_head.ch, exp_head.drive, o_drive);
                    err_count++;
                end
                if (o_saturated !== exp_head.saturated) begin
                    $display("%0t: ch %0d saturated mismatch: expected %0b, got %0b",
                             $time, exp_head.ch, exp_head.saturated, o_saturated);
                    err_count++;
                end
            end
        end
    end

    // Result-side stall pattern, with an optional long hold-off.
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (rx_mode)
                RX_OPEN:  i_out_stall <= 1'b0;
                RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                default:  i_out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // Watchdog: abort when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_pid_controller_four_channel_unit: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------
    task automatic send_item(input logic func, input logic [CH_IDX_W-1:0] ch,
                             input logic signed [SPEED_W-1:0] sp,
                             input logic signed [SPEED_W-1:0] ms,
                             input logic [DT_W-1:0] dt);
        if (gaps_on && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_channel   <= ch;
        i_setpoint  <= sp;
        i_measured  <= ms;
        i_step_time <= dt;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        drive_expected.push_back(predict_drive(func, ch, sp, ms, dt));
        items_sent++;
        if (func == FUNC_CLEAR)
            clears_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // Drop valid in the step of the last acceptance, then wait for all results.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (drive_expected.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_gains(input logic [GAIN_W-1:0] kp,
                              input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd);
        logic [GAIN_W-1:0] vals [3];
        logic [CFG_IDX_W-1:0] idx [3];
        vals = '{kp, ki, kd};
        idx  = '{REG_PROP_GAIN, REG_INTEG_GAIN, REG_DERIV_GAIN};
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            case (idx[k])
                REG_PROP_GAIN:  kp_model = longint'(vals[k]);
                REG_INTEG_GAIN: ki_model = longint'(vals[k]);
                REG_DERIV_GAIN: kd_model = longint'(vals[k]);
                default: ;
            endcase
            gain_writes++;
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SPEED_W-1:0] clip_speed(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[SPEED_W-1:0];
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return GAIN_W'($urandom_range(0, 65535) >> $urandom_range(0, 12));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_gains();
        gaps_on = 1'b1;
        rx_mode = RX_LIGHT;
        send_item(FUNC_UPDATE, 2'd0, 16'sh7FFF, 16'sh8000, 16'hFFFF);
        send_item(FUNC_UPDATE, 2'd0, 16'sh8000, 16'sh7FFF, 16'hFFFF);
        send_item(FUNC_UPDATE, 2'd1, 16'sd100, 16'sd40, 16'h0000);
        send_item(FUNC_UPDATE, 2'd1, 16'sd0, 16'sd0, 16'h0001);
        send_item(FUNC_CLEAR,  2'd0, 16'sd0, 16'sd0, 16'h0000);
        send_item(FUNC_UPDATE, 2'd0, 16'sd1000, 16'sd0, 16'd655);
        send_item(FUNC_UPDATE, 2'd2, -16'sd1, 16'sd0, 16'hFFFF);
        send_item(FUNC_UPDATE, 2'd3, 16'sh7FFF, 16'sh7FFF, 16'h8000);
        send_item(FUNC_CLEAR,  2'd3, 16'sh7FFF, 16'sh8000, 16'hFFFF);
        send_item(FUNC_CLEAR,  2'd1, 16'sd0, 16'sd0, 16'h0000);
        drain();
    endtask

    task automatic test_gain_extremes();
        gaps_on = 1'b0;
        rx_mode = RX_OPEN;
        load_gains('1, '1, '1);
        send_item(FUNC_UPDATE, 2'd2, 16'sh7FFF, 16'sh8000, 16'h0001);
        send_item(FUNC_UPDATE, 2'd2, 16'sh8000, 16'sh7FFF, 16'h0001);
        send_item(FUNC_UPDATE, 2'd3, 16'sd20, 16'sd10, 16'h0000);
        send_item(FUNC_UPDATE, 2'd0, 16'sd5, 16'sd3, 16'hFFFF);
        drain();
        load_gains('0, '0, '0);
        send_item(FUNC_UPDATE, 2'd1, 16'sh7FFF, 16'sh8000, 16'hFFFF);
        send_item(FUNC_UPDATE, 2'd1, 16'sh8000, 16'sh7FFF, 16'h0001);
        send_item(FUNC_CLEAR,  2'd2, 16'sd0, 16'sd0, 16'h0000);
        drain();
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int run_len;
        int spv, msv;
        logic [CH_IDX_W-1:0] ch;
        logic [DT_W-1:0] dt;
        sent = 0;
        load_gains(pick_gain(), pick_gain(), pick_gain());
        gaps_on = $urandom_range(0, 2) != 0;
        rx_mode = t_rx_mode'($urandom_range(0, 2));
        while (sent < n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                // noise: any field value, clears included
                send_item(1'($urandom_range(0, 1)),
                          CH_IDX_W'($urandom_range(0, NUM_CH - 1)),
                          SPEED_W'($urandom_range(0, 65535)),
                          SPEED_W'($urandom_range(0, 65535)),
                          DT_W'($urandom_range(0, 65535)));
                sent++;
            end else begin
                // control loop run: fixed setpoint, measurement closes in
                ch      = CH_IDX_W'($urandom_range(0, NUM_CH - 1));
                run_len = $urandom_range(3, 12);
                spv     = int'($urandom_range(0, 65535)) - 32768;
                msv     = int'($urandom_range(0, 65535)) - 32768;
                dt      = ($urandom_range(0, 1) != 0) ? DT_W'($urandom_range(1, 4096))
                                                       : DT_W'($urandom_range(1, 65535));
                if ($urandom_range(0, 2) == 0) begin
                    send_item(FUNC_CLEAR, ch, clip_speed(spv), clip_speed(msv), dt);
                    sent++;
                end
                for (int k = 0; k < run_len && sent < n_items; k++) begin
                    if ($urandom_range(0, 19) == 0)
                        dt = '0;
                    else if ($urandom_range(0, 5) == 0)
                        dt = DT_W'($urandom_range(1, 65535));
                    send_item(FUNC_UPDATE, ch, clip_speed(spv), clip_speed(msv), dt);
                    sent++;
                    msv = msv + (spv - msv) / 3 + int'($urandom_range(0, 64)) - 32;
                end
            end
        end
        drain();
    endtask

    // Hold results off long enough that the block backs up into its input.
    task automatic test_backpressure();
        gaps_on = 1'b0;
        rx_mode = RX_OPEN;
        load_gains(pick_gain(), pick_gain(), pick_gain());
        hold_requests++;
        for (int k = 0; k < 12; k++)
            send_item($urandom_range(0, 4) == 0,
                      CH_IDX_W'($urandom_range(0, NUM_CH - 1)),
                      SPEED_W'($urandom_range(0, 65535)),
                      SPEED_W'($urandom_range(0, 65535)),
                      DT_W'($urandom_range(0, 65535)));
        drain();
    endtask

    initial begin
        reset_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_gains();
        test_gain_extremes();
        for (int ph = 0; ph < 8; ph++)
            test_random_traffic(110);
        test_backpressure();
        test_random_traffic(20);

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Ran %0d transactions (%0d clears) over %0d gain writes;",
                 items_sent, clears_sent, gain_writes);
        $display("%0d results came back saturated, %0d mismatches.", sat_seen, err_count);
        if (err_count == 0)
            $display("tb_pid_controller_four_channel_unit: PASS");
        else
            $display("tb_pid_controller_four_channel_unit: FAIL");
        $finish;
    end

endmodule
